// ----- rtl/core/lfp_pkg.sv -----
// Shared types and constants for the long-filename entry packer.
package lfp_pkg;

	localparam int unsigned UNITS = 13;
	localparam int unsigned ORD_W = 6;
	localparam logic [3:0] LAST_SLOT = 4'd12;
	localparam logic [6:0] FINAL_FLAG = 7'h40;
	localparam logic [15:0] FILLER_UNIT = 16'hFFFF;
	localparam logic [15:0] TERM_UNIT = 16'h0000;

	typedef struct packed {
		logic [7:0] name_byte;
		logic       byte_valid;
		logic       end_of_name;
	} item_t;

	typedef struct packed {
		logic [6:0]  order_byte;
		logic [3:0]  slot;
		logic [15:0] code_unit;
		logic        entry_done;
		logic        overflow;
	} result_t;

	typedef struct packed {
		logic [UNITS-1:0][7:0] chars;
		logic [3:0]            fill;
		logic                  final_entry;
		logic [6:0]            order_byte;
		logic                  overflow;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// ----- rtl/core/lfp_front.sv -----
// Front end: accepts name bytes, gathers them into an entry and hands finished entries on.
module lfp_front #(
	parameter int unsigned MAX_ENTRIES = 20
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              q_full,
	input  lfp_pkg::item_t    item,
	output logic              item_stall,
	output logic              push,
	output lfp_pkg::entry_t   push_entry
);

	localparam logic [lfp_pkg::ORD_W-1:0] ORD_LIMIT =
		(lfp_pkg::ORD_W'(MAX_ENTRIES) == '0) ? lfp_pkg::ORD_W'(1) : lfp_pkg::ORD_W'(MAX_ENTRIES);

	logic [7:0]                store_q [lfp_pkg::UNITS];
	logic [3:0]                fill_q;
	logic [lfp_pkg::ORD_W-1:0] ordinal_q;
	logic                      overflow_q;

	logic       accept;
	logic       store_en;
	logic [3:0] fill_next;
	logic       emit;

	assign item_stall = q_full;
	assign accept     = item_valid && !q_full;
	assign store_en   = item.byte_valid && (fill_q < 4'(lfp_pkg::UNITS));
	assign fill_next  = store_en ? 4'(fill_q + 4'd1) : fill_q;
	assign emit       = item.end_of_name || (fill_next == 4'(lfp_pkg::UNITS));
	assign push       = accept && emit;

	always_comb begin
		for (int k = 0; k < lfp_pkg::UNITS; k++) begin
			if (store_en && (fill_q == 4'(k))) begin
				push_entry.chars[k] = item.name_byte;
			end else begin
				push_entry.chars[k] = store_q[k];
			end
		end
		push_entry.fill        = fill_next;
		push_entry.final_entry = item.end_of_name;
		push_entry.order_byte  = {1'b0, ordinal_q} | (item.end_of_name ? lfp_pkg::FINAL_FLAG : 7'd0);
		push_entry.overflow    = overflow_q;
	end

	always_ff @(posedge clk) begin
		if (accept && store_en) begin
			store_q[fill_q] <= item.name_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= 4'd0;
			ordinal_q  <= lfp_pkg::ORD_W'(1);
			overflow_q <= 1'b0;
		end else if (accept) begin
			if (item.end_of_name) begin
				fill_q     <= 4'd0;
				ordinal_q  <= lfp_pkg::ORD_W'(1);
				overflow_q <= 1'b0;
			end else if (emit) begin
				fill_q <= 4'd0;
				if (ordinal_q >= ORD_LIMIT) begin
					overflow_q <= 1'b1;
					ordinal_q  <= ORD_LIMIT;
				end else begin
					ordinal_q <= ordinal_q + lfp_pkg::ORD_W'(1);
				end
			end else begin
				fill_q <= fill_next;
			end
		end
	end

endmodule

// ----- rtl/core/lfp_queue.sv -----
// Two-deep queue of finished entries between front and back ends.
module lfp_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  lfp_pkg::entry_t     push_entry,
	input  logic                pop,
	output lfp_pkg::entry_t     head,
	output lfp_pkg::q_status_t  status
);

	lfp_pkg::entry_t slots_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;

	assign head         = slots_q[rd_ptr_q];
	assign status.full  = (count_q == 2'd2);
	assign status.empty = (count_q == 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ----- rtl/core/lfp_back.sv -----
// Back end: walks the head entry slot by slot into a registered result stage.
module lfp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  lfp_pkg::entry_t     head,
	input  lfp_pkg::q_status_t  status,
	input  logic                result_stall,
	output logic                pop,
	output logic                result_valid,
	output lfp_pkg::result_t    result
);

	logic             valid_q;
	lfp_pkg::result_t result_q;
	logic [3:0]       slot_q;
	logic             load;
	logic [15:0]      unit;

	assign load         = !status.empty && (!valid_q || !result_stall);
	assign pop          = load && (slot_q == lfp_pkg::LAST_SLOT);
	assign result_valid = valid_q;
	assign result       = result_q;

	always_comb begin
		if (slot_q < head.fill) begin
			unit = {8'd0, head.chars[slot_q]};
		end else if (head.final_entry && (slot_q == head.fill)) begin
			unit = lfp_pkg::TERM_UNIT;
		end else begin
			unit = lfp_pkg::FILLER_UNIT;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q.order_byte <= head.order_byte;
			result_q.slot       <= slot_q;
			result_q.code_unit  <= unit;
			result_q.entry_done <= (slot_q == lfp_pkg::LAST_SLOT);
			result_q.overflow   <= head.overflow;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			slot_q  <= 4'd0;
		end else if (load) begin
			valid_q <= 1'b1;
			slot_q  <= (slot_q == lfp_pkg::LAST_SLOT) ? 4'd0 : 4'(slot_q + 4'd1);
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

endmodule

// ----- rtl/core/lfn_entry_packer.sv -----
// Top level of the long-filename entry packer.
//   channel | direction | handshake                    | payload
//   item    | in        | item_valid / item_stall      | lfp_pkg::item_t
//   result  | out       | result_valid / result_stall  | lfp_pkg::result_t
// The front end takes a name byte unless stalled; it stalls only while both queue slots hold
// finished entries. Each entry leaves as 13 results, one per cycle unless result_stall holds,
// so full entries sustain one byte per cycle; a name closed early still yields 13 results
// for its last entry. A finished entry goes through a queue slot, then the result register.
// Reset empties the queue and the result stage; no clearing pass is needed.
module lfn_entry_packer #(
	parameter int unsigned MAX_ENTRIES = 20
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  lfp_pkg::item_t    item,
	output logic              result_valid,
	input  logic              result_stall,
	output lfp_pkg::result_t  result
);

	logic               push;
	logic               pop;
	lfp_pkg::entry_t    push_entry;
	lfp_pkg::entry_t    head;
	lfp_pkg::q_status_t status;

	lfp_front #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.q_full     (status.full),
		.item       (item),
		.item_stall (item_stall),
		.push       (push),
		.push_entry (push_entry)
	);

	lfp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (status)
	);

	lfp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.status       (status),
		.result_stall (result_stall),
		.pop          (pop),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

// ----- rtl/core/lfp_checker.sv -----
// Port-level checks for the long-filename entry packer, bound to the top level.
module lfp_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             result_valid,
	input  logic             result_stall,
	input  lfp_pkg::result_t result
);

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.entry_done |-> result.slot == lfp_pkg::LAST_SLOT)
		else $error("entry_done away from the last slot");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && !result.entry_done |=>
			result_valid && (result.slot == 4'($past(result.slot) + 4'd1)))
		else $error("slots of an entry not delivered back to back");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && !result.entry_done |=>
			(result.order_byte == $past(result.order_byte))
			&& (result.overflow == $past(result.overflow)))
		else $error("order byte or overflow changed inside an entry");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result transaction changed");

endmodule

bind lfn_entry_packer lfp_checker u_lfp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
